// ===== hdl/stb_pkg.sv =====
// Soft timer bank package: sizes, entry layout, command and status codes.
// Used by the top level and the checker; depends on nothing.
package stb_pkg;

   localparam int GROUP_COUNT      = 4;
   localparam int TIMERS_PER_GROUP = 16;
   localparam int MAX_RESULTS      = 16;

   localparam int GRP_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int TMR_W  = (TIMERS_PER_GROUP > 1) ? $clog2(TIMERS_PER_GROUP) : 1;
   localparam int LEN_W  = $clog2(TIMERS_PER_GROUP + 1);
   localparam int RPT_W  = $clog2(MAX_RESULTS + 1);
   localparam int ADDR_W = GRP_W + TMR_W;
   localparam int DEPTH  = 1 << ADDR_W;

   // entry word: count, reload, auto-reload flag, enable flag
   localparam int WORD_W = 66;

   localparam logic [3:0] CMD_TICK    = 4'd0;
   localparam logic [3:0] CMD_RUN     = 4'd1;
   localparam logic [3:0] CMD_CREATE  = 4'd2;
   localparam logic [3:0] CMD_REMOVE  = 4'd3;
   localparam logic [3:0] CMD_READY   = 4'd4;
   localparam logic [3:0] CMD_RESET   = 4'd5;
   localparam logic [3:0] CMD_PAUSE   = 4'd6;
   localparam logic [3:0] CMD_RESUME  = 4'd7;
   localparam logic [3:0] CMD_QUERY   = 4'd8;
   localparam logic [3:0] CMD_ELAPSED = 4'd9;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BAD_IDX  = 2'd2;

   localparam logic CSR_GROUPS    = 1'b0;
   localparam logic CSR_TICK_RUNS = 1'b1;

endpackage

// ===== hdl/stb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/soft_timer_bank.sv =====
// Soft timer bank top level: command sequencer around one entry RAM.
// Depends on stb_pkg and stb_ram.
//
//   channel | direction | handshake        | payload
//   req_    | in        | req_valid/stall  | command, indices, create and elapsed operands
//   rsp_    | out       | rsp_valid/stall  | status, slot, expired, running, elapsed, last
//   csr_    | in        | csr_write_en     | groups_in_use, tick_runs_first_group
//
// One command at a time. Tick counts down each enabled entry of all groups in use,
// then scans group 0 when tick_runs_first_group is set; run scans one group; remove
// shifts later slots down. One RAM entry is visited per cycle unless a scan is held.
// Reset is synchronous and clears control state; RAM contents stay undefined.
// A stalled result holds the sequencer only when another result is ready to go.
module soft_timer_bank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic [1:0]  req_group_index,
   input  logic [3:0]  req_timer_index,
   input  logic [31:0] req_reload_value,
   input  logic        req_auto_reload,
   input  logic        req_start_enabled,
   input  logic [31:0] req_earlier_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic        rsp_expired,
   output logic        rsp_running,
   output logic [31:0] rsp_elapsed_ticks,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);
   import stb_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_TICK  = 4'd2;
   localparam logic [3:0] S_TEND  = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_SEND  = 4'd5;
   localparam logic [3:0] S_SHIFT = 4'd6;
   localparam logic [3:0] S_PMOD  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [3:0]       cmd_ff, cmd_in;
   logic [1:0]       gidx_ff, gidx_in;
   logic [3:0]       tidx_ff, tidx_in;
   logic [31:0]      rel_ff, rel_in;
   logic             ar_ff, ar_in;
   logic             sen_ff, sen_in;
   logic [31:0]      early_ff, early_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic [LEN_W-1:0] slot_ff, slot_in;
   logic [31:0]      tick_total_ff, tick_total_in;
   logic [2:0]       cfg_groups_ff, cfg_groups_in;
   logic             cfg_trun_ff, cfg_trun_in;
   logic [LEN_W-1:0] glen_ff [GROUP_COUNT];
   logic [LEN_W-1:0] glen_in [GROUP_COUNT];
   logic             pend_ff, pend_in;
   logic [LEN_W-1:0] pend_slot_ff, pend_slot_in;
   logic [RPT_W-1:0] rpt_ff, rpt_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [3:0]       res_slot_ff, res_slot_in;
   logic             res_run_ff, res_run_in;
   logic [31:0]      res_el_ff, res_el_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_expired_ff, rsp_expired_in;
   logic             rsp_running_ff, rsp_running_in;
   logic [31:0]      rsp_el_ff, rsp_el_in;
   logic             rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic [31:0]      rd_count, rd_reload;
   logic             rd_rflag, rd_eflag;
   logic [LEN_W-1:0] len_cur;
   logic [4:0]       active;
   logic             gvalid, tvalid, out_free, report;
   logic [ADDR_W-1:0] addr_cur;

   stb_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_count  = ram_rdata[65:34];
   assign rd_reload = ram_rdata[33:2];
   assign rd_rflag  = ram_rdata[1];
   assign rd_eflag  = ram_rdata[0];
   assign len_cur   = glen_ff[grp_ff];
   assign addr_cur  = {grp_ff, slot_ff[TMR_W-1:0]};
   // read ahead: the entry at the next slot is ready when the slot pointer gets there
   assign ram_raddr = {grp_in, slot_in[TMR_W-1:0]};
   assign active    = ({2'b0, cfg_groups_ff} > 5'(GROUP_COUNT)) ? 5'(GROUP_COUNT)
                                                                : {2'b0, cfg_groups_ff};
   assign gvalid    = {3'b0, gidx_ff} < active;
   assign tvalid    = 8'(tidx_ff) < 8'(len_cur);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign report    = rpt_ff < RPT_W'(MAX_RESULTS);

   assign req_stall         = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_expired       = rsp_expired_ff;
   assign rsp_running       = rsp_running_ff;
   assign rsp_elapsed_ticks = rsp_el_ff;
   assign rsp_last          = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      gidx_in        = gidx_ff;
      tidx_in        = tidx_ff;
      rel_in         = rel_ff;
      ar_in          = ar_ff;
      sen_in         = sen_ff;
      early_in       = early_ff;
      grp_in         = grp_ff;
      slot_in        = slot_ff;
      tick_total_in  = tick_total_ff;
      cfg_groups_in  = cfg_groups_ff;
      cfg_trun_in    = cfg_trun_ff;
      glen_in        = glen_ff;
      pend_in        = pend_ff;
      pend_slot_in   = pend_slot_ff;
      rpt_in         = rpt_ff;
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_run_in     = res_run_ff;
      res_el_in      = res_el_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_running_in = rsp_running_ff;
      rsp_el_in      = rsp_el_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = addr_cur;
      ram_wdata      = ram_rdata;

      if (csr_write_en) begin
         if (csr_index == CSR_GROUPS) begin
            cfg_groups_in = csr_wdata;
         end else begin
            cfg_trun_in = csr_wdata[0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               gidx_in  = req_group_index;
               tidx_in  = req_timer_index;
               rel_in   = req_reload_value;
               ar_in    = req_auto_reload;
               sen_in   = req_start_enabled;
               early_in = req_earlier_tick;
               grp_in   = GRP_W'(req_group_index);
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_status_in = ST_OK;
            res_slot_in   = 4'd0;
            res_run_in    = 1'b0;
            res_el_in     = 32'd0;
            state_in      = S_EMIT;
            if (cmd_ff == CMD_TICK) begin
               tick_total_in = tick_total_ff + 32'd1;
               grp_in        = '0;
               slot_in       = '0;
               state_in      = (active == 5'd0) ? S_TEND : S_TICK;
            end else if (cmd_ff == CMD_ELAPSED) begin
               res_el_in = tick_total_ff - early_ff;
            end else if (cmd_ff > CMD_ELAPSED) begin
               res_status_in = ST_OK;
            end else if (!gvalid) begin
               res_status_in = ST_BAD_IDX;
            end else if (cmd_ff == CMD_RUN) begin
               slot_in  = '0;
               pend_in  = 1'b0;
               rpt_in   = '0;
               state_in = S_SCAN;
            end else if (cmd_ff == CMD_CREATE) begin
               if (len_cur >= LEN_W'(TIMERS_PER_GROUP)) begin
                  res_status_in = ST_NO_SPACE;
               end else begin
                  ram_we          = 1'b1;
                  ram_waddr       = {grp_ff, len_cur[TMR_W-1:0]};
                  ram_wdata       = {rel_ff, rel_ff, ar_ff, sen_ff};
                  glen_in[grp_ff] = len_cur + LEN_W'(1);
                  res_slot_in     = 4'(len_cur);
               end
            end else if (!tvalid) begin
               res_status_in = ST_BAD_IDX;
            end else if (cmd_ff == CMD_REMOVE) begin
               slot_in  = LEN_W'(tidx_ff) + LEN_W'(1);
               state_in = S_SHIFT;
            end else begin
               slot_in  = LEN_W'(tidx_ff);
               state_in = S_PMOD;
            end
         end
         S_TICK: begin
            if (slot_ff >= len_cur) begin
               // next group in use, or done
               if ((5'(grp_ff) + 5'd1) >= active) begin
                  state_in = S_TEND;
               end else begin
                  grp_in  = grp_ff + GRP_W'(1);
                  slot_in = '0;
               end
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {(rd_eflag && rd_count != 32'd0) ? rd_count - 32'd1 : rd_count,
                            rd_reload, rd_rflag, rd_eflag};
               slot_in   = slot_ff + LEN_W'(1);
            end
         end
         S_TEND: begin
            if (cfg_trun_ff) begin
               grp_in   = '0;
               slot_in  = '0;
               pend_in  = 1'b0;
               rpt_in   = '0;
               state_in = S_SCAN;
            end else begin
               res_status_in = ST_OK;
               res_slot_in   = 4'd0;
               res_run_in    = 1'b0;
               res_el_in     = 32'd0;
               state_in      = S_EMIT;
            end
         end
         S_SCAN: begin
            if (slot_ff >= len_cur) begin
               state_in = S_SEND;
            end else if (rd_count != 32'd0) begin
               slot_in = slot_ff + LEN_W'(1);
            end else if (!(report && pend_ff && !out_free)) begin
               // reload; a one-shot timer stops
               ram_we    = 1'b1;
               ram_wdata = {rd_reload, rd_reload, rd_rflag, rd_rflag && rd_eflag};
               slot_in   = slot_ff + LEN_W'(1);
               if (report) begin
                  if (pend_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = ST_OK;
                     rsp_slot_in    = 4'(pend_slot_ff);
                     rsp_expired_in = 1'b1;
                     rsp_running_in = 1'b0;
                     rsp_el_in      = 32'd0;
                     rsp_last_in    = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = slot_ff;
                  rpt_in       = rpt_ff + RPT_W'(1);
               end
            end
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_slot_in    = pend_ff ? 4'(pend_slot_ff) : 4'd0;
               rsp_expired_in = pend_ff;
               rsp_running_in = 1'b0;
               rsp_el_in      = 32'd0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (slot_ff >= len_cur) begin
               glen_in[grp_ff] = len_cur - LEN_W'(1);
               res_status_in   = ST_OK;
               res_slot_in     = 4'd0;
               res_run_in      = 1'b0;
               res_el_in       = 32'd0;
               state_in        = S_EMIT;
            end else begin
               // move entry down by one slot
               ram_we    = 1'b1;
               ram_waddr = {grp_ff, slot_ff[TMR_W-1:0] - TMR_W'(1)};
               slot_in   = slot_ff + LEN_W'(1);
            end
         end
         S_PMOD: begin
            res_status_in = ST_OK;
            res_slot_in   = 4'd0;
            res_run_in    = 1'b0;
            res_el_in     = 32'd0;
            state_in      = S_EMIT;
            case (cmd_ff)
               CMD_READY: begin
                  ram_we    = 1'b1;
                  ram_wdata = {32'd0, rd_reload, rd_rflag, 1'b1};
               end
               CMD_RESET: begin
                  ram_we    = 1'b1;
                  ram_wdata = {rd_reload, rd_reload, rd_rflag, 1'b1};
               end
               CMD_PAUSE: begin
                  ram_we    = 1'b1;
                  ram_wdata = {rd_count, rd_reload, rd_rflag, 1'b0};
               end
               CMD_RESUME: begin
                  ram_we    = 1'b1;
                  ram_wdata = {rd_count, rd_reload, rd_rflag, 1'b1};
               end
               default: begin
                  res_run_in = rd_eflag;
               end
            endcase
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_slot_in    = res_slot_ff;
               rsp_expired_in = 1'b0;
               rsp_running_in = res_run_ff;
               rsp_el_in      = res_el_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         tick_total_ff <= '0;
         cfg_groups_ff <= '0;
         cfg_trun_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rpt_ff        <= '0;
         for (int i = 0; i < GROUP_COUNT; i++) begin
            glen_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         tick_total_ff <= tick_total_in;
         cfg_groups_ff <= cfg_groups_in;
         cfg_trun_ff   <= cfg_trun_in;
         pend_ff       <= pend_in;
         rpt_ff        <= rpt_in;
         glen_ff       <= glen_in;
      end
      cmd_ff         <= cmd_in;
      gidx_ff        <= gidx_in;
      tidx_ff        <= tidx_in;
      rel_ff         <= rel_in;
      ar_ff          <= ar_in;
      sen_ff         <= sen_in;
      early_ff       <= early_in;
      grp_ff         <= grp_in;
      slot_ff        <= slot_in;
      pend_slot_ff   <= pend_slot_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_run_ff     <= res_run_in;
      res_el_ff      <= res_el_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_running_ff <= rsp_running_in;
      rsp_el_ff      <= rsp_el_in;
      rsp_last_ff    <= rsp_last_in;
   end
endmodule

// ===== hdl/stb_checker.sv =====
// Port-level checks for the soft timer bank, bound to the top level.
// Depends on soft_timer_bank and stb_pkg.
module stb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_slot_index,
   input logic        rsp_expired,
   input logic        rsp_last
);
   import stb_pkg::*;

   // a transfer in blocks the next request until its results are out
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a non-final result belongs to a scan with more expiries to come
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_expired && req_stall)
      else $error("non-final result outside a scan");

   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expired |-> rsp_status == ST_OK)
      else $error("expiry reported with error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index) && $stable(rsp_last))
      else $error("stalled result changed");
endmodule

bind soft_timer_bank stb_checker u_stb_checker (.*);
